// File: src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 7;

	// Value reported as head when the queue holds nothing.
	localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Operation codes carried in the input word.
	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	// One stored slot.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] prio;
	} entry_t;

	// What a cell hands to its right-hand neighbor.
	typedef struct packed {
		entry_t entry;
		logic   stay;
	} link_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t item;
	} cmd_t;

endpackage
`default_nettype wire

// File: src/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts right on insert, left on removal.
`default_nettype none
module spq_cell #(
	parameter bit IS_HEAD = 1'b0
) (
	input  wire logic           clk,
	input  wire spq_pkg::cmd_t  cmd,
	input  wire logic           used,
	input  wire spq_pkg::link_t left,
	input  wire spq_pkg::entry_t right,
	output spq_pkg::link_t      link,
	output spq_pkg::entry_t     nxt,
	output logic                hit
);
	import spq_pkg::*;

	entry_t entry_q;
	logic   ahead;

	// New item ranks behind this slot (head keeps its place on ties)
	always_comb begin
		if (IS_HEAD) begin
			ahead = !($signed(cmd.item.prio) > $signed(entry_q.prio));
		end else begin
			ahead = $signed(cmd.item.prio) < $signed(entry_q.prio);
		end
	end

	assign link.stay  = used && ahead;
	assign link.entry = entry_q;

	// Insert lands here when everything to the left stays and this slot does not
	assign hit = cmd.enq && left.stay && !link.stay;

	// Next slot contents
	always_comb begin
		nxt = entry_q;
		if (cmd.enq) begin
			if (link.stay) begin
				nxt = entry_q;
			end else if (left.stay) begin
				nxt = cmd.item;
			end else begin
				nxt = left.entry;
			end
		end else if (cmd.deq) begin
			nxt = right;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= nxt;
	end

endmodule
`default_nettype wire

// File: src/sorted_priority_queue.sv
// A result word is registered and valid in the cycle after its input word is accepted.
// One operation per cycle while result words are read as they appear; every cell compares and shifts in parallel.
// Input stalls while a result word waits; it reopens in the cycle that word is read.
// Reset clears the entry count and the output valid flag; slot contents are not
// cleared, as slots at or beyond the count are never read.
`default_nettype none
module sorted_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [0] opcode, [32:1] item_value, [64:33] item_priority, [71:65] zero
	input  wire logic [71:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] accepted, [7:1] compare_count, [39:8] head_value, [71:40] head_priority,
	// [72] queue_empty, [79:73] entry_total
	output logic [79:0]      m_axis_tdata
);
	import spq_pkg::*;

	localparam int OCC_W = $clog2(CAPACITY + 1);

	logic [OCC_W-1:0] occ_q, occ_d;
	logic             s_acc, enq_go, deq_go;
	op_t              op;
	cmd_t             cmd;
	link_t            links [CAPACITY+1];
	entry_t           rights [CAPACITY+1];
	entry_t           nxts [CAPACITY];
	logic [CAPACITY-1:0] hits;
	logic [CAPACITY-1:0] used;
	logic [OCC_W-1:0] cnt;
	logic [OCC_W+CNT_W-1:0] cnt_ext, occ_ext;

	logic             m_valid_q;
	logic             acc_q;
	logic [CNT_W-1:0] cmp_q;
	logic [DATA_W-1:0] head_val_q, head_pri_q;
	logic             empty_q;
	logic [CNT_W-1:0] total_q;

	// Input handshake and decode
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign s_acc  = s_axis_tvalid && s_axis_tready;
	assign op     = op_t'(s_axis_tdata[0]);
	assign enq_go = s_acc && (op == OP_ENQUEUE) && (occ_q != OCC_W'(CAPACITY));
	assign deq_go = s_acc && (op == OP_DEQUEUE) && (occ_q != '0);

	assign cmd.enq        = enq_go;
	assign cmd.deq        = deq_go;
	assign cmd.item.value = s_axis_tdata[32:1];
	assign cmd.item.prio  = s_axis_tdata[64:33];

	// Chain ends: head always sees "stay" on its left, tail pulls in nothing
	assign links[0].stay  = 1'b1;
	assign links[0].entry = cmd.item;
	assign rights[CAPACITY] = '0;

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign used[i]  = OCC_W'(i) < occ_q;
		assign rights[i] = links[i+1].entry;
		spq_cell #(
			.IS_HEAD(i == 0)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.used (used[i]),
			.left (links[i]),
			.right(rights[i+1]),
			.link (links[i+1]),
			.nxt  (nxts[i]),
			.hit  (hits[i])
		);
	end

	// Compare count: insert slot plus one, OR of one-hot masked constants
	always_comb begin
		cnt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			cnt = cnt | (hits[i] ? OCC_W'(i + 1) : '0);
		end
	end

	// Entry count update
	always_comb begin
		occ_d = occ_q;
		if (enq_go) begin
			occ_d = occ_q + 1'b1;
		end else if (deq_go) begin
			occ_d = occ_q - 1'b1;
		end
	end

	assign cnt_ext = {{CNT_W{1'b0}}, cnt};
	assign occ_ext = {{CNT_W{1'b0}}, occ_d};

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
			if (s_acc) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (s_acc) begin
			acc_q      <= !((op == OP_ENQUEUE) && (occ_q == OCC_W'(CAPACITY)));
			cmp_q      <= cnt_ext[CNT_W-1:0];
			empty_q    <= (occ_d == '0);
			total_q    <= occ_ext[CNT_W-1:0];
			head_val_q <= (occ_d == '0) ? INT_MIN : nxts[0].value;
			head_pri_q <= (occ_d == '0) ? '0 : nxts[0].prio;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {total_q, empty_q, head_pri_q, head_val_q, cmp_q, acc_q};

	// Checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(CAPACITY))
		else $error("entry count above capacity");

	a_hit_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hits))
		else $error("more than one insert slot");

	a_enq_hit: assert property (@(posedge clk) disable iff (!arst_n)
		enq_go |-> $onehot(hits))
		else $error("accepted enqueue found no insert slot");

	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> m_axis_tvalid)
		else $error("accepted word produced no result");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		enq_go |=> occ_q == $past(occ_q) + 1'b1)
		else $error("enqueue did not grow the queue");

endmodule
`default_nettype wire

// File: test/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: random stream traffic vs. a shadow queue.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int QCAP         = 64;
	localparam int TARGET_WORDS = 1100;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 10;
	localparam logic [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	// Input word: op, value, priority, zero fill (LSB first)
	typedef struct packed {
		logic [6:0]        pad;
		logic [DATA_W-1:0] prio;
		logic [DATA_W-1:0] value;
		op_t               op;
	} op_word_t;

	// Output word: accepted, compare count, head value, head priority, empty, total (LSB first)
	typedef struct packed {
		logic [CNT_W-1:0]  entry_total;
		logic              queue_empty;
		logic [DATA_W-1:0] head_priority;
		logic [DATA_W-1:0] head_value;
		logic [CNT_W-1:0]  compare_count;
		logic              accepted;
	} snapshot_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;

	// Shadow copy of the sorted store, slot 0 is the head
	logic signed [DATA_W-1:0] shadow_val [QCAP];
	logic signed [DATA_W-1:0] shadow_pri [QCAP];
	int shadow_count = 0;

	// Stimulus and bookkeeping
	op_word_t  pending_ops[$];
	bit        drain_mark[$];
	snapshot_t awaited_snapshots[$];
	int        plan_count = 0;
	int        total_words = 0;
	int        words_sent = 0;
	int        words_in = 0;
	int        results_seen = 0;
	int        fail_count = 0;
	int        stall_cycles = 0;
	int        full_rejects = 0;
	int        empty_dequeues = 0;
	int        head_inserts = 0;
	int        peak_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	bit        in_taken;
	snapshot_t got;
	snapshot_t want;
	string     bad;

	sorted_priority_queue #(.CAPACITY(QCAP)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Apply one operation to the shadow queue and return the state it leaves
	function automatic snapshot_t step_sorted_queue(input op_word_t w);
		snapshot_t r;
		int pos;
		r = '0;
		r.accepted = 1'b1;
		if (w.op == OP_ENQUEUE) begin
			if (shadow_count >= QCAP) begin
				r.accepted = 1'b0;
				full_rejects++;
			end else begin
				if (shadow_count == 0 || $signed(w.prio) > shadow_pri[0]) begin
					pos = 0;
					r.compare_count = CNT_W'(1);
					head_inserts++;
				end else begin
					pos = 1;
					while (pos < shadow_count && $signed(w.prio) < shadow_pri[pos])
						pos++;
					r.compare_count = CNT_W'(pos + 1);
				end
				for (int i = shadow_count; i > pos; i--) begin
					shadow_val[i] = shadow_val[i-1];
					shadow_pri[i] = shadow_pri[i-1];
				end
				shadow_val[pos] = w.value;
				shadow_pri[pos] = w.prio;
				shadow_count++;
				if (shadow_count > peak_count)
					peak_count = shadow_count;
			end
		end else if (shadow_count == 0) begin
			empty_dequeues++;
		end else begin
			for (int i = 0; i < shadow_count - 1; i++) begin
				shadow_val[i] = shadow_val[i+1];
				shadow_pri[i] = shadow_pri[i+1];
			end
			shadow_count--;
		end
		if (shadow_count == 0) begin
			r.head_value    = INT_MIN;
			r.head_priority = '0;
			r.queue_empty   = 1'b1;
		end else begin
			r.head_value    = shadow_val[0];
			r.head_priority = shadow_pri[0];
			r.queue_empty   = 1'b0;
		end
		r.entry_total = CNT_W'(shadow_count);
		return r;
	endfunction

	function automatic string fmt_snapshot(input snapshot_t r);
		return $sformatf("acc=%0b cmp=%0d head=%0d pri=%0d empty=%0b total=%0d",
			r.accepted, r.compare_count, $signed(r.head_value),
			$signed(r.head_priority), r.queue_empty, r.entry_total);
	endfunction

	// Append one word to the stimulus, tracking occupancy as planned
	task automatic plan_word(input op_t op, input logic [DATA_W-1:0] value,
			input logic [DATA_W-1:0] prio, input bit hold);
		op_word_t w;
		w = '0;
		w.op    = op;
		w.value = value;
		w.prio  = prio;
		pending_ops.push_back(w);
		drain_mark.push_back(hold);
		if (op == OP_ENQUEUE && plan_count < QCAP)
			plan_count++;
		else if (op == OP_DEQUEUE && plan_count > 0)
			plan_count--;
	endtask

	// Mostly a narrow band to force ties, sometimes anything, sometimes extremes
	function automatic logic [DATA_W-1:0] pick_prio();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return DATA_W'($urandom_range(6)) - DATA_W'(3);
			5, 6:          return $urandom;
			7:             return INT_MAX - DATA_W'($urandom_range(1));
			8:             return INT_MIN + DATA_W'($urandom_range(1));
			default:       return {$urandom_range(1) ? 1'b1 : 1'b0, (DATA_W-1)'($urandom)};
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0:       return INT_MIN;
			1:       return INT_MAX;
			2:       return '1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic plan_random(input int enq_pct);
		if ($urandom_range(99) < enq_pct)
			plan_word(OP_ENQUEUE, pick_value(), pick_prio(), $urandom_range(99) == 0);
		else
			plan_word(OP_DEQUEUE, pick_value(), pick_prio(), $urandom_range(99) == 0);
	endtask

	// Driver for both handshakes; changes on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (words_sent < total_words / 3) begin
				send_idle_pct = 32;
				recv_idle_pct = 72;
			end else if (words_sent < 2 * total_words / 3) begin
				send_idle_pct = 72;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (!s_axis_tvalid || in_taken) begin
				if (pending_ops.size() == 0 || $urandom_range(99) < send_idle_pct
						|| (drain_mark[0] && awaited_snapshots.size() != 0)) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_ops.pop_front();
					void'(drain_mark.pop_front());
					words_sent++;
				end
			end
		end
	end

	// Monitor: check results first, then record the word taken at this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				results_seen++;
				if (awaited_snapshots.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: unexpected result word: %s", fmt_snapshot(got));
				end else begin
					want = awaited_snapshots.pop_front();
					bad = "";
					if (got.accepted !== want.accepted)           bad = {bad, " accepted"};
					if (got.compare_count !== want.compare_count) bad = {bad, " compare_count"};
					if (got.head_value !== want.head_value)       bad = {bad, " head_value"};
					if (got.head_priority !== want.head_priority) bad = {bad, " head_priority"};
					if (got.queue_empty !== want.queue_empty)     bad = {bad, " queue_empty"};
					if (got.entry_total !== want.entry_total)     bad = {bad, " entry_total"};
					if (bad != "") begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: result %0d wrong in%s\n  exp %s\n  got %s",
								results_seen, bad, fmt_snapshot(want), fmt_snapshot(got));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				awaited_snapshots.push_back(step_sorted_queue(s_axis_tdata));
				words_in++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog on cycles with no word moving
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("ERROR: no handshake for %0d cycles, %0d words pending",
			STALL_LIMIT, pending_ops.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int seg_len;
		int mode;
		bit first_seg;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;

		// Directed: empty dequeue, head inserts, ties at head and in body, extremes
		plan_word(OP_DEQUEUE, '0, '0, 1'b0);
		plan_word(OP_ENQUEUE, INT_MAX, '0, 1'b0);
		plan_word(OP_ENQUEUE, INT_MIN, '0, 1'b0);
		plan_word(OP_ENQUEUE, '1, INT_MAX, 1'b0);
		plan_word(OP_ENQUEUE, 32'd1, INT_MIN, 1'b0);
		plan_word(OP_ENQUEUE, 32'd2, '0, 1'b0);
		plan_word(OP_ENQUEUE, 32'd3, '1, 1'b0);
		plan_word(OP_ENQUEUE, 32'd4, INT_MIN, 1'b0);
		plan_word(OP_ENQUEUE, '0, '1, 1'b0);
		plan_word(OP_ENQUEUE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		plan_word(OP_ENQUEUE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		repeat (12) plan_word(OP_DEQUEUE, '1, '1, 1'b0);
		plan_word(OP_ENQUEUE, INT_MIN, INT_MIN, 1'b1);
		plan_word(OP_DEQUEUE, '0, '0, 1'b0);

		// Random segments: fill, drain, mixed, and full-then-empty sweeps
		first_seg = 1'b1;
		while (pending_ops.size() < TARGET_WORDS) begin
			mode = first_seg ? 3 : $urandom_range(4);
			first_seg = 1'b0;
			seg_len = $urandom_range(10, 60);
			case (mode)
				0:       repeat (seg_len) plan_random(85);
				1:       repeat (seg_len) plan_random(15);
				2:       repeat (seg_len) plan_random(50);
				default: begin
					while (plan_count < QCAP) plan_random(92);
					repeat ($urandom_range(2, 5))
						plan_word(OP_ENQUEUE, pick_value(), pick_prio(), 1'b0);
					while (plan_count > 0) plan_random(10);
					plan_word(OP_DEQUEUE, pick_value(), pick_prio(), 1'b0);
				end
			endcase
		end
		total_words = pending_ops.size();
		// Let everything drain at each change of idling pattern
		drain_mark[total_words / 3]     = 1'b1;
		drain_mark[2 * total_words / 3] = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_axis_tvalid || awaited_snapshots.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (awaited_snapshots.size() != 0)
			fail_count++;

		$display("Ran %0d operations, checked %0d result words, peak occupancy %0d.",
			words_in, results_seen, peak_count);
		$display("Full-queue rejects %0d, empty dequeues %0d, head inserts %0d, failures %0d.",
			full_rejects, empty_dequeues, head_inserts, fail_count);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

// File: sorted_priority_queue.f
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
test/tb_sorted_priority_queue.sv
